// ===== rtl/bpa_pkg.sv =====
`default_nettype none
package bpa_pkg;
	localparam int NUM_PAGES_DEF  = 4096;
	localparam int NUM_ORDERS_DEF = 10;
	localparam int ORDER_W = 4;
	localparam int PAGE_W  = 12;
	localparam int COUNT_W = 13;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	typedef struct packed {
		logic              func;
		logic [ORDER_W-1:0] order;
		logic [PAGE_W-1:0]  page;
	} bpa_in_t;

	typedef struct packed {
		logic [PAGE_W-1:0]  block_page;
		logic               ok;
		logic [COUNT_W-1:0] free_count;
	} bpa_out_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_A_SCAN,
		ST_A_RDNEXT,
		ST_A_WAITNEXT,
		ST_A_POP,
		ST_A_TOG,
		ST_A_SPLIT,
		ST_A_SPLIT2,
		ST_A_DONE,
		ST_F_TOGRD,
		ST_F_TOGWAIT,
		ST_F_TOG,
		ST_F_UNRD,
		ST_F_UNWAIT,
		ST_F_UNLINK,
		ST_F_UNLINK2,
		ST_F_PUSH,
		ST_F_PUSH2,
		ST_F_DONE,
		ST_OUT
	} bpa_state_t;
endpackage
`default_nettype wire

// ===== rtl/bpa_link_ram.sv =====
`default_nettype none
module bpa_link_ram
	import bpa_pkg::*;
#(
	parameter int DEPTH = NUM_PAGES_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int DW    = AW + 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/buddy_page_allocator_unit.sv =====
// buddy page allocator: allocates and frees power-of-two page blocks
// in: valid/ready word {func, order, page}; func 0 alloc, 1 free
// out: valid/ready word {block_page, ok, free_count}, one per request
// one request at a time under a sequencer; in_ready is low while busy
// alloc: scans up the orders for a free block, pops it, then splits it
// down to the requested order and finishes; free: merges with its buddy
// order by order while the pair bit shows the buddy free (no test at the
// top order), then pushes the block and finishes; a rejected order goes
// straight to the result word; each memory has a single read port
// the next word can be taken in the cycle after the result word is taken
// a result word blocks new requests until the receiver takes it; a stalled
// receiver holds the block with the word unchanged
// reset empties the lists and zeroes the count, then a clearing pass over
// all NUM_ORDERS * NUM_PAGES / 2 pair bits (20480 by default) zeroes
// them with in_ready low
// rejected orders answer ok 0 with state unchanged
`default_nettype none
module buddy_page_allocator_unit
	import bpa_pkg::*;
#(
	parameter int NUM_PAGES  = NUM_PAGES_DEF,
	parameter int NUM_ORDERS = NUM_ORDERS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire bpa_in_t in_data,
	output logic         out_valid,
	input  wire logic    out_ready,
	output bpa_out_t     out_data
);
	localparam int AW  = $clog2(NUM_PAGES);
	localparam int LW  = AW + 1;
	localparam int OW  = $clog2(NUM_ORDERS + 1);
	localparam int BW  = AW + $clog2(NUM_ORDERS);
	localparam logic [LW-1:0] NIL = LW'(NUM_PAGES);
	localparam logic [LW:0]   NP  = (LW+1)'(NUM_PAGES);

	// pair bits: one memory indexed {order, pair}; pair index uses AW-1 bits
	localparam int PDEPTH = NUM_ORDERS << (AW - 1);
	localparam int PAW    = $clog2(PDEPTH);

	bpa_state_t state_q, state_d;

	logic [LW-1:0]   head_q [NUM_ORDERS];
	logic [LW-1:0]   free_q;
	logic [OW-1:0]   req_q;
	logic [OW-1:0]   o_q;
	logic [AW-1:0]   p_q;
	logic [LW-1:0]   n_q;
	bpa_out_t        res_q;
	logic            res_v_q;
	logic [PAW-1:0]  clr_q;

	// link memories
	logic          nx_we, pv_we;
	logic [AW-1:0] nx_wa, pv_wa, nx_ra, pv_ra;
	logic [LW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;

	bpa_link_ram #(.DEPTH(NUM_PAGES), .AW(AW), .DW(LW)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
		.raddr(nx_ra), .rdata(nx_rd)
	);
	bpa_link_ram #(.DEPTH(NUM_PAGES), .AW(AW), .DW(LW)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
		.raddr(pv_ra), .rdata(pv_rd)
	);

	// pair bit memory, zeroed by the clearing pass after reset
	logic            pair_mem [PDEPTH];
	logic            pb_we;
	logic [PAW-1:0]  pb_a;
	logic            pb_wd;
	logic            pb_rd_q;
	logic            pb_cur;

	always_ff @(posedge clk) begin
		if (pb_we) pair_mem[pb_a] <= pb_wd;
		pb_rd_q <= pair_mem[pb_a];
	end
	assign pb_cur = pb_rd_q;

	function automatic logic [PAW-1:0] pair_addr(input logic [OW-1:0] o,
	                                             input logic [AW-1:0] p);
		logic [AW-1:0] sh;
		sh = p >> (o + OW'(1));
		return PAW'(BW'(o) * BW'(NUM_PAGES / 2) + BW'(sh[AW-2:0]));
	endfunction

	function automatic logic [AW-1:0] bit_of(input logic [OW-1:0] o);
		return AW'(1) << o;
	endfunction

	function automatic logic [AW-1:0] mask_of(input logic [OW-1:0] o);
		return ~((AW'(1) << o) - AW'(1));
	endfunction

	logic [OW-1:0] req_ord;
	assign req_ord = OW'(in_data.order);

	logic head_is_page;
	logic [LW-1:0] cur_head;
	assign cur_head = head_q[o_q[$clog2(NUM_ORDERS)-1:0]];
	assign head_is_page = (cur_head < NIL);
	logic [$clog2(NUM_ORDERS)-1:0] oi;
	assign oi = o_q[$clog2(NUM_ORDERS)-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == PAW'(PDEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE: if (in_valid && in_ready) begin
				if (32'(in_data.order) >= NUM_ORDERS) state_d = ST_OUT;
				else if (in_data.func == FUNC_ALLOC) state_d = ST_A_SCAN;
				else state_d = ST_F_TOGRD;
			end
			ST_A_SCAN: begin
				if (32'(o_q) >= NUM_ORDERS) state_d = ST_A_DONE;
				else if (head_is_page) state_d = ST_A_RDNEXT;
			end
			ST_A_RDNEXT:   state_d = ST_A_WAITNEXT;
			ST_A_WAITNEXT: state_d = ST_A_POP;
			ST_A_POP:      state_d = ST_A_TOG;
			ST_A_TOG:      state_d = (o_q > req_q) ? ST_A_SPLIT : ST_A_DONE;
			ST_A_SPLIT:    state_d = ST_A_SPLIT2;
			ST_A_SPLIT2:   state_d = (o_q > req_q) ? ST_A_SPLIT : ST_A_DONE;
			ST_A_DONE:     state_d = ST_OUT;
			ST_F_TOGRD: begin
				if (32'(o_q) >= NUM_ORDERS - 1) state_d = ST_F_PUSH;
				else state_d = ST_F_TOGWAIT;
			end
			ST_F_TOGWAIT:  state_d = ST_F_TOG;
			// bit set before the toggle means the buddy is free
			ST_F_TOG:      state_d = pb_cur ? ST_F_UNRD : ST_F_PUSH;
			ST_F_UNRD:     state_d = ST_F_UNWAIT;
			ST_F_UNWAIT:   state_d = ST_F_UNLINK;
			ST_F_UNLINK:   state_d = ST_F_UNLINK2;
			ST_F_UNLINK2:  state_d = ST_F_TOGRD;
			ST_F_PUSH:     state_d = ST_F_PUSH2;
			ST_F_PUSH2:    state_d = ST_F_DONE;
			ST_F_DONE:     state_d = ST_OUT;
			ST_OUT:        state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// memory port drive
	logic [AW-1:0] buddy;
	assign buddy = p_q ^ bit_of(o_q);

	always_comb begin
		nx_we = 1'b0; nx_wa = '0; nx_wd = '0; nx_ra = '0;
		pv_we = 1'b0; pv_wa = '0; pv_wd = '0; pv_ra = '0;
		pb_we = 1'b0; pb_a = pair_addr(o_q, p_q); pb_wd = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				pb_we = 1'b1; pb_a = clr_q; pb_wd = 1'b0;
			end
			ST_A_RDNEXT, ST_A_WAITNEXT: nx_ra = cur_head[AW-1:0];
			ST_A_POP: begin
				pb_a = pair_addr(o_q, cur_head[AW-1:0]);
				if (nx_rd < NIL) begin
					pv_we = 1'b1; pv_wa = nx_rd[AW-1:0]; pv_wd = NIL;
				end
			end
			ST_A_TOG: begin
				pb_we = 1'b1; pb_wd = ~pb_cur;
			end
			ST_A_SPLIT: begin
				// front half pushed at order o-1
				pb_a = pair_addr(o_q - OW'(1), p_q);
				nx_we = 1'b1; nx_wa = p_q;
				nx_wd = (head_q[oi - 1'b1] < NIL) ? head_q[oi - 1'b1] : NIL;
				pv_we = 1'b1; pv_wa = p_q; pv_wd = NIL;
			end
			ST_A_SPLIT2: begin
				pb_a = pair_addr(o_q, p_q);
				pb_we = 1'b1; pb_wd = ~pb_cur;
				if (n_q < NIL) begin
					pv_we = 1'b1; pv_wa = n_q[AW-1:0]; pv_wd = LW'(p_q);
				end
			end
			ST_F_UNRD: begin
				pb_we = 1'b1; pb_wd = 1'b0;
				nx_ra = buddy; pv_ra = buddy;
			end
			ST_F_UNWAIT: begin
				nx_ra = buddy; pv_ra = buddy;
			end
			ST_F_TOG: if (!pb_cur) begin
				pb_we = 1'b1; pb_wd = 1'b1;
			end
			ST_F_UNLINK: begin
				if (pv_rd < NIL) begin
					nx_we = 1'b1; nx_wa = pv_rd[AW-1:0];
					nx_wd = (nx_rd < NIL) ? nx_rd : NIL;
				end
				if (nx_rd < NIL) begin
					pv_we = 1'b1; pv_wa = nx_rd[AW-1:0];
					pv_wd = (pv_rd < NIL) ? pv_rd : NIL;
				end
			end
			ST_F_PUSH: begin
				nx_we = 1'b1; nx_wa = p_q;
				nx_wd = head_is_page ? cur_head : NIL;
				pv_we = 1'b1; pv_wa = p_q; pv_wd = NIL;
			end
			ST_F_PUSH2: begin
				if (n_q < NIL) begin
					pv_we = 1'b1; pv_wa = n_q[AW-1:0]; pv_wd = LW'(p_q);
				end
			end
			default: ;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE) && !res_v_q;
	assign out_valid = res_v_q;
	assign out_data  = res_q;

	logic [LW:0] fsum;
	assign fsum = {1'b0, free_q} + ((LW+1)'(1) << req_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			for (int i = 0; i < NUM_ORDERS; i++) head_q[i] <= NIL;
			free_q  <= '0;
			res_v_q <= 1'b0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid && out_ready) res_v_q <= 1'b0;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + PAW'(1);
				ST_A_SCAN: begin
					if (32'(o_q) < NUM_ORDERS && !head_is_page) o_q <= o_q + OW'(1);
				end
				ST_A_POP: begin
					head_q[oi] <= (nx_rd < NIL) ? nx_rd : NIL;
					p_q <= cur_head[AW-1:0];
				end
				ST_A_SPLIT: begin
					o_q <= o_q - OW'(1);
					n_q <= head_q[oi - 1'b1];
					head_q[oi - 1'b1] <= LW'(p_q);
				end
				ST_A_SPLIT2: p_q <= p_q + bit_of(o_q);
				ST_A_DONE: begin
					if (32'(o_q) < NUM_ORDERS) begin
						res_q.ok <= 1'b1;
						res_q.block_page <= PAGE_W'(p_q);
						free_q <= (free_q >= (LW'(1) << req_q)) ?
							free_q - (LW'(1) << req_q) : '0;
					end
				end
				ST_F_UNLINK: begin
					if (!(pv_rd < NIL)) head_q[oi] <= (nx_rd < NIL) ? nx_rd : NIL;
				end
				ST_F_UNLINK2: begin
					o_q <= o_q + OW'(1);
					p_q <= p_q & mask_of(o_q + OW'(1));
				end
				ST_F_PUSH: begin
					n_q <= cur_head;
					head_q[oi] <= LW'(p_q);
				end
				ST_F_DONE: begin
					res_q.ok <= 1'b1; res_q.block_page <= '0;
					free_q <= (fsum > NP) ? NIL : fsum[LW-1:0];
				end
				ST_OUT: begin
					res_q.free_count <= COUNT_W'(free_q);
					res_v_q <= 1'b1;
				end
				default: ;
			endcase
			if (state_q == ST_IDLE && in_valid && in_ready) begin
				req_q  <= req_ord;
				o_q    <= req_ord;
				p_q    <= AW'(in_data.page) & mask_of(req_ord);
				res_q.ok <= 1'b0;
				res_q.block_page <= '0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/bpa_checker.sv =====
`default_nettype none
module bpa_checker
	import bpa_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     in_valid,
	input wire logic     in_ready,
	input wire bpa_in_t  in_data,
	input wire logic     out_valid,
	input wire logic     out_ready,
	input wire bpa_out_t out_data
);
	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word dropped while stalled");
	ap_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("took a request while a result waits");
	ap_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.ok |-> out_data.block_page == '0)
		else $error("failed result with nonzero page");
	ap_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.free_count <= COUNT_W'(NUM_PAGES_DEF))
		else $error("free count out of range");
endmodule

bind buddy_page_allocator_unit bpa_checker u_bpa_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
	.out_data(out_data)
);
`default_nettype wire

// ===== dv/tb_buddy_page_allocator_unit.sv =====
`default_nettype none
module tb_buddy_page_allocator_unit;
	import bpa_pkg::*;

	localparam int NPAGES   = NUM_PAGES_DEF;
	localparam int NORDERS  = NUM_ORDERS_DEF;
	localparam int NIL      = NPAGES;
	localparam int MAX_CYC  = 400000;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	bpa_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	bpa_out_t out_data;

	buddy_page_allocator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #5 clk = ~clk;

	// allocator shadow state
	int   head_of[NORDERS];
	int   nxt_of[NPAGES];
	int   prv_of[NPAGES];
	bit   buddy_bit[NORDERS][NPAGES/2];
	int   pages_free;

	bpa_out_t answers_due[$];
	int   held_blocks[$];
	int   held_orders[$];
	int   failures = 0;
	longint cycles = 0;
	int   hold_off = 0;
	bit   rx_quiet = 1'b0;

	function automatic bit flip_bit(int o, int p);
		int idx;
		idx = (p >> (o + 1)) % (NPAGES / 2);
		buddy_bit[o][idx] ^= 1'b1;
		return buddy_bit[o][idx];
	endfunction

	function automatic bit valid_pg(int v);
		return v >= 0 && v < NPAGES;
	endfunction

	function automatic void link_front(int o, int p);
		int h;
		h = head_of[o];
		nxt_of[p] = valid_pg(h) ? h : NIL;
		prv_of[p] = NIL;
		if (valid_pg(h))
			prv_of[h] = p;
		head_of[o] = p;
	endfunction

	function automatic void drop_link(int o, int p);
		int n, pr;
		n = nxt_of[p];
		pr = prv_of[p];
		if (!valid_pg(n))
			n = NIL;
		if (valid_pg(pr))
			nxt_of[pr] = n;
		else
			head_of[o] = n;
		if (valid_pg(n))
			prv_of[n] = valid_pg(pr) ? pr : NIL;
	endfunction

	function automatic bpa_out_t allocate_or_free(bpa_in_t w);
		bpa_out_t r;
		int o, ret, n, need, p;
		r = '0;
		o = w.order;
		if (w.order < NORDERS) begin
			if (w.func == FUNC_ALLOC) begin
				while (o < NORDERS && !valid_pg(head_of[o]))
					o++;
				if (o < NORDERS) begin
					ret = head_of[o];
					n = nxt_of[ret];
					need = 1 << w.order;
					head_of[o] = valid_pg(n) ? n : NIL;
					if (valid_pg(n))
						prv_of[n] = NIL;
					void'(flip_bit(o, ret));
					while (o > w.order) begin
						o--;
						link_front(o, ret);
						void'(flip_bit(o, ret));
						ret = (ret + (1 << o)) % NPAGES;
					end
					pages_free = (pages_free >= need) ? pages_free - need : 0;
					r.block_page = ret[PAGE_W-1:0];
					r.ok = 1'b1;
				end
			end else begin
				p = int'(w.page) & ~((1 << o) - 1);
				while (o < NORDERS - 1) begin
					if (flip_bit(o, p))
						break;
					drop_link(o, (p ^ (1 << o)) % NPAGES);
					o++;
					p &= ~((1 << o) - 1);
				end
				link_front(o, p);
				pages_free += 1 << w.order;
				if (pages_free > NPAGES)
					pages_free = NPAGES;
				r.ok = 1'b1;
			end
		end
		r.free_count = pages_free[COUNT_W-1:0];
		return r;
	endfunction

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 45) return 0;
		if (k < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_word(bit f, int o, int p);
		bpa_in_t w;
		int g;
		w.func = f;
		w.order = o[ORDER_W-1:0];
		w.page = p[PAGE_W-1:0];
		answers_due.push_back(allocate_or_free(w));
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic give_back_all();
		while (held_blocks.size() > 0)
			send_word(FUNC_FREE, held_orders.pop_front(), held_blocks.pop_front());
	endtask

	task automatic grab(int o);
		bpa_out_t e;
		send_word(FUNC_ALLOC, o, $urandom_range(0, 4095));
		e = answers_due[$];
		if (e.ok) begin
			held_blocks.push_back(e.block_page);
			held_orders.push_back(o);
		end
	endtask

	task automatic test_seed_memory();
		// memory starts empty; free all eight top blocks so allocs can succeed
		send_word(FUNC_ALLOC, 0, 0);
		for (int i = 0; i < NPAGES; i += 1 << (NORDERS - 1))
			send_word(FUNC_FREE, NORDERS - 1, i + $urandom_range(0, 511));
	endtask

	task automatic test_directed();
		grab(0);
		grab(9);
		grab(5);
		send_word(FUNC_ALLOC, 10, 4095);
		send_word(FUNC_FREE, 15, 4095);
		send_word(FUNC_ALLOC, 15, 0);
		grab(9);
		grab(9);
		grab(9);
		grab(3);
		give_back_all();
		grab(9); grab(9); grab(9); grab(9); grab(9);
		give_back_all();
	endtask

	task automatic test_backpressure();
		rx_quiet = 1'b1;
		hold_off = 300;
		for (int i = 0; i < 12; i++)
			grab($urandom_range(0, 4));
		rx_quiet = 1'b0;
		give_back_all();
	endtask

	task automatic test_random();
		int k, j;
		for (int i = 0; i < 600; i++) begin
			k = $urandom_range(0, 99);
			if (k < 2)
				send_word($urandom_range(0, 1), $urandom_range(10, 15), $urandom);
			else if (k < 50 || held_blocks.size() == 0)
				grab($urandom_range(0, 100) < 85 ? $urandom_range(0, 4)
					: $urandom_range(0, 9));
			else begin
				j = $urandom_range(0, held_blocks.size() - 1);
				// page offset inside the block is masked off by the block
				send_word(FUNC_FREE, held_orders[j],
					held_blocks[j] | $urandom_range(0, (1 << held_orders[j]) - 1));
				held_blocks.delete(j);
				held_orders.delete(j);
			end
		end
		give_back_all();
	endtask

	// receiver with random stalls and one long hold-off
	initial begin
		int g;
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				out_ready <= 1'b0;
				hold_off--;
			end else if (!rx_quiet) begin
				g = $urandom_range(0, 99);
				if (g >= 97) begin
					out_ready <= 1'b0;
					hold_off = $urandom_range(10, 50);
				end else
					out_ready <= (g < 60) || (g < 70 && $urandom_range(0, 1) == 0);
			end else
				out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		bpa_out_t e;
		if (arst_n && out_valid && out_ready) begin
			if (answers_due.size() == 0) begin
				$error("result word with nothing expected");
				failures++;
			end else begin
				e = answers_due.pop_front();
				if (out_data.block_page !== e.block_page) begin
					$error("block_page expected %0d actual %0d", e.block_page,
						out_data.block_page);
					failures++;
				end
				if (out_data.ok !== e.ok) begin
					$error("ok expected %0d actual %0d", e.ok, out_data.ok);
					failures++;
				end
				if (out_data.free_count !== e.free_count) begin
					$error("free_count expected %0d actual %0d", e.free_count,
						out_data.free_count);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYC) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		for (int o = 0; o < NORDERS; o++)
			head_of[o] = NIL;
		for (int i = 0; i < NPAGES; i++) begin
			nxt_of[i] = 0;
			prv_of[i] = 0;
		end
		for (int o = 0; o < NORDERS; o++)
			for (int i = 0; i < NPAGES / 2; i++)
				buddy_bit[o][i] = 1'b0;
		pages_free = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_seed_memory();
		test_directed();
		test_backpressure();
		test_random();
		in_valid <= 1'b0;
		while (answers_due.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/bpa_pkg.sv
rtl/bpa_link_ram.sv
rtl/buddy_page_allocator_unit.sv
rtl/bpa_checker.sv
dv/tb_buddy_page_allocator_unit.sv
